@@ hdl/esoq_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and codes for the elevator sweep order queue.
// No dependencies; imported by elevator_sweep_order_queue.
package esoq_pkg;

   localparam int CODE_W   = 2'd0 + 4;
   localparam int ACTION_W = 2;
   localparam int STATUS_W = 2;

   typedef enum logic [ACTION_W-1:0] {
      ACT_ADD   = 2'd0,
      ACT_DEL   = 2'd1,
      ACT_CLEAR = 2'd2,
      ACT_QUERY = 2'd3
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_DONE    = 2'd0,
      STAT_DUP     = 2'd1,
      STAT_INVALID = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WALK,
      ST_DEL,
      ST_CLR,
      ST_HEAD
   } state_type;

endpackage

@@ hdl/elevator_sweep_order_queue.sv @@
`timescale 1ns / 1ps
// Elevator stop-order ring kept in sweep order, driven by a slot-serial sequencer.
// Depends on esoq_pkg for action, status and state codes.
//
// Usage: one request on req_* yields exactly one response on rsp_*.
// A request carries the action in req_tuser and the order code and last
// move in req_tdata. The response carries the head order after the request,
// whether the normalized order code is queued, and a status code.
// Sequence, with SLOTS = 2*(FLOORS-1): every request first scans all slots
// through one compare unit, one slot a cycle. Query and rejected adds then
// load the response. A delete first empties the head slot and advances the
// head. An accepted add walks the ring from the head, one slot a cycle, over
// at most SLOTS slots, stopping at the first empty one. A clear sweeps every
// slot to empty.
// req_tready is high only while the sequencer is idle.
// The response sits in an output register; a stalled receiver holds the
// next response in the load step until the register is taken.
// Reset (synchronous, active high) empties every slot and zeroes the head.
module elevator_sweep_order_queue
   import esoq_pkg::*;
#(
   parameter int FLOORS = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   // [3:0] order_code, [7:4] last_move
   input  logic [7:0] req_tdata,
   // [1:0] action
   input  logic [1:0] req_tuser,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   // [3:0] head_order, [4] order_present, [6:5] status, [7] zero
   output logic [7:0] rsp_tdata
);

   localparam int SLOTS  = 2 * (FLOORS - 1);
   localparam int POS_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int MAG_W  = $clog2(FLOORS + 1) + 1;
   localparam int SLOT_W = (MAG_W > CODE_W) ? MAG_W : CODE_W;

   typedef logic signed [SLOT_W-1:0] slot_type;
   typedef logic [POS_W-1:0]         pos_type;

   function automatic logic pos_ok(input slot_type c);
      int ci;
      ci = int'(c);
      return (ci < 0 && ci >= -(FLOORS - 1)) || (ci >= 2 && ci <= FLOORS);
   endfunction

   function automatic pos_type sweep_pos(input slot_type c);
      int ci;
      ci = int'(c);
      if (ci < 0) return pos_type'(ci + FLOORS - 1);
      else        return pos_type'(ci + FLOORS - 3);
   endfunction

   function automatic pos_type sweep_dist(input pos_type p, input pos_type lp);
      int d;
      d = int'(p) - int'(lp) - 1;
      if (d < 0) d = d + SLOTS;
      return pos_type'(d);
   endfunction

   function automatic slot_type normalize(input slot_type c);
      int ci;
      ci = int'(c);
      if (ci == -FLOORS || ci == 1) return slot_type'(-ci);
      else                          return c;
   endfunction

   function automatic pos_type wrap_inc(input pos_type p);
      if (p == pos_type'(SLOTS - 1)) return '0;
      else                           return pos_type'(p + 1'b1);
   endfunction

   state_type  state_ff, state_in;
   slot_type   slots_ff [SLOTS];
   pos_type    ptr_ff, ptr_in;
   pos_type    head_ff, head_in;
   pos_type    cnt_ff, cnt_in;
   pos_type    lp_ff, lp_in;
   action_type action_ff, action_in;
   slot_type   code_ff, code_in;
   slot_type   carry_ff, carry_in;
   logic       code_ok_ff, code_ok_in;
   logic       last_ok_ff, last_ok_in;
   logic       found_ff, found_in;
   logic       present_ff, present_in;
   status_type status_ff, status_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_data_ff, rsp_data_in;

   logic signed [CODE_W-1:0] req_code;
   logic signed [CODE_W-1:0] req_last;
   slot_type   req_code_x, req_last_x;
   slot_type   rd;
   logic       slot_we;
   slot_type   slot_wdata;
   logic       match, found_now, last_ptr, out_free, carry_wins;

   assign req_code   = req_tdata[3:0];
   assign req_last   = req_tdata[7:4];
   assign req_code_x = slot_type'(int'(req_code));
   assign req_last_x = slot_type'(int'(req_last));

   assign rd         = slots_ff[ptr_ff];
   assign match      = (rd == code_ff) && (code_ff != '0);
   assign found_now  = found_ff | match;
   assign last_ptr   = (ptr_ff == pos_type'(SLOTS - 1));
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign carry_wins = sweep_dist(sweep_pos(carry_ff), lp_ff) < sweep_dist(sweep_pos(rd), lp_ff);

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (last_ptr) begin
               unique case (action_ff)
                  ACT_ADD: begin
                     if (code_ok_ff && last_ok_ff && !found_now) state_in = ST_WALK;
                     else                                         state_in = ST_HEAD;
                  end
                  ACT_DEL:   state_in = ST_DEL;
                  ACT_CLEAR: state_in = ST_CLR;
                  default:   state_in = ST_HEAD;
               endcase
            end
         end
         ST_WALK: begin
            if (rd == '0 || cnt_ff == pos_type'(SLOTS - 1)) state_in = ST_HEAD;
         end
         ST_DEL: state_in = ST_HEAD;
         ST_CLR: begin
            if (last_ptr) state_in = ST_HEAD;
         end
         ST_HEAD: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      ptr_in       = ptr_ff;
      head_in      = head_ff;
      cnt_in       = cnt_ff;
      lp_in        = lp_ff;
      action_in    = action_ff;
      code_in      = code_ff;
      carry_in     = carry_ff;
      code_ok_in   = code_ok_ff;
      last_ok_in   = last_ok_ff;
      found_in     = found_ff;
      present_in   = present_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      slot_we      = 1'b0;
      slot_wdata   = carry_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               action_in  = action_type'(req_tuser);
               code_in    = normalize(req_code_x);
               code_ok_in = pos_ok(normalize(req_code_x));
               last_ok_in = pos_ok(req_last_x);
               lp_in      = sweep_pos(req_last_x);
               found_in   = 1'b0;
               status_in  = STAT_DONE;
               ptr_in     = '0;
            end
         end
         ST_SCAN: begin
            found_in = found_now;
            ptr_in   = wrap_inc(ptr_ff);
            if (last_ptr) begin
               present_in = found_now;
               ptr_in     = head_ff;
               unique case (action_ff)
                  ACT_ADD: begin
                     if (!code_ok_ff || !last_ok_ff) begin
                        status_in = STAT_INVALID;
                     end else if (found_now) begin
                        status_in = STAT_DUP;
                     end else begin
                        cnt_in   = '0;
                        carry_in = code_ff;
                     end
                  end
                  ACT_CLEAR: ptr_in = '0;
                  default: ;
               endcase
            end
         end
         ST_WALK: begin
            if (rd == '0) begin
               slot_we    = 1'b1;
               present_in = 1'b1;
               ptr_in     = head_ff;
            end else begin
               if (carry_wins) begin
                  slot_we  = 1'b1;
                  carry_in = rd;
               end
               if (cnt_ff == pos_type'(SLOTS - 1)) begin
                  present_in = 1'b1;
                  ptr_in     = head_ff;
               end else begin
                  ptr_in = wrap_inc(ptr_ff);
                  cnt_in = pos_type'(cnt_ff + 1'b1);
               end
            end
         end
         ST_DEL: begin
            if (match) present_in = 1'b0;
            slot_we    = 1'b1;
            slot_wdata = '0;
            head_in    = wrap_inc(ptr_ff);
            ptr_in     = wrap_inc(ptr_ff);
         end
         ST_CLR: begin
            slot_we    = 1'b1;
            slot_wdata = '0;
            ptr_in     = wrap_inc(ptr_ff);
            if (last_ptr) begin
               head_in    = '0;
               ptr_in     = '0;
               present_in = 1'b0;
            end
         end
         ST_HEAD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {1'b0, status_ff, present_ff, rd[CODE_W-1:0]};
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ptr_ff       <= '0;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < SLOTS; i++) slots_ff[i] <= '0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
         if (slot_we) slots_ff[ptr_ff] <= slot_wdata;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      lp_ff       <= lp_in;
      action_ff   <= action_in;
      code_ff     <= code_in;
      carry_ff    <= carry_in;
      code_ok_ff  <= code_ok_in;
      last_ok_ff  <= last_ok_in;
      found_ff    <= found_in;
      present_ff  <= present_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
